/* design/logical_line_splicer_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the logical line splicer
// Clocked on i_clk and disabled while i_rst_n is low; empty when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef LOGICAL_LINE_SPLICER_ASSERT_SVH
`define LOGICAL_LINE_SPLICER_ASSERT_SVH
`ifndef SYNTH
`define LLS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("logical line splicer: assertion failed");
`define LLS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("logical line splicer: assertion failed");
`else
`define LLS_ASSERT_SAME(lbl, ante, cons)
`define LLS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* design/lls_pkg.sv */
// ---------------------------------------------------------------------------
// Logical line splicer package
// Operation codes, result kinds, queue sizing and byte constants.
// ---------------------------------------------------------------------------
package lls_pkg;

    localparam logic [7:0] LF_BYTE      = 8'h0A;
    localparam logic [7:0] CR_BYTE      = 8'h0D;
    localparam logic [7:0] ESCAPE_RESET = 8'h2F;

    // two entries per queue; pointers wrap explicitly
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_CHAR     = 2'd0,
        KIND_BOOKMARK = 2'd1,
        KIND_LINE_END = 2'd2
    } t_kind;

    // work handed from the front to the back
    typedef enum logic [2:0] {
        OP_CHAR,          // emit byte0
        OP_CHAR_PAIR,     // emit byte0, then byte1
        OP_CHAR_LINE_END, // emit byte0, then end the line
        OP_LINE_END,      // end the line
        OP_BOOKMARK       // advance row, emit splice bookmark
    } t_op_code;

    typedef struct packed {
        t_op_code    code;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
    } t_op;

    typedef enum logic {
        BK_FIRST,
        BK_SECOND
    } t_back_state;

endpackage

/* design/logical_line_splicer.sv */
// ---------------------------------------------------------------------------
// Logical line splicer
// Split a raw byte stream into logical lines with escape-newline splicing.
// ---------------------------------------------------------------------------
// Usage:
//   Input queue side: drive i_data_byte / i_end_of_file with push; a beat is
//   taken on a clock edge with push high and full low. Result queue side: a
//   result beat is on the o_* ports while empty is low and leaves on an edge
//   with pop high. Each input beat causes zero, one or two result beats; the
//   last one carries o_last.
//   Configuration: the escape byte is written through i_cfg_valid /
//   o_cfg_ready (always ready) while the block is idle; reset value is '/'.
//   Path: front end, operation queue, back end, result queue. Throughput:
//   one input beat per cycle while full is low; a two-result item holds the
//   back end until both are queued; one result write per cycle while not full.
//   Reset (synchronous, active low) empties both queues, clears the escape
//   and CR tracking, sets the row to 1 and the offset to 0.
//   Stall: when pop stays low the result queue fills, the back end holds,
//   the operation queue fills and full rises; no beat is lost.
// ---------------------------------------------------------------------------
module logical_line_splicer #(
    parameter int OFFSET_WIDTH = 16,
    parameter int ROW_WIDTH    = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [7:0]              i_cfg_escape_byte,
    // input queue
    input  logic                    push,
    output logic                    full,
    input  logic [7:0]              i_data_byte,
    input  logic                    i_end_of_file,
    // result queue
    output logic                    empty,
    input  logic                    pop,
    output logic [1:0]              o_kind,
    output logic [7:0]              o_char_out,
    output logic [ROW_WIDTH-1:0]    o_raw_row,
    output logic [OFFSET_WIDTH-1:0] o_line_offset,
    output logic                    o_offset_overflow,
    output logic                    o_last
);

    logic         accept;
    logic         op_valid;
    lls_pkg::t_op op_in;
    lls_pkg::t_op op_head;
    logic         op_empty;
    logic         op_pop;

    // register writes never stall
    assign o_cfg_ready = 1'b1;

    // take a beat whenever the operation queue has room
    assign accept = push && !full;

    // front: classify beats, track escape and CR LF state
    lls_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_escape_byte (i_cfg_escape_byte),
        .i_accept          (accept),
        .i_data_byte       (i_data_byte),
        .i_end_of_file     (i_end_of_file),
        .o_op_valid        (op_valid),
        .o_op              (op_in)
    );

    // decouple front and back; its fill level drives full
    lls_fifo #(
        .WIDTH ($bits(lls_pkg::t_op))
    ) u_op_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (op_valid),
        .i_wdata (op_in),
        .i_rd    (op_pop),
        .o_rdata (op_head),
        .o_full  (full),
        .o_empty (op_empty)
    );

    // back: advance row and offset, emit result beats
    lls_back #(
        .OFFSET_WIDTH (OFFSET_WIDTH),
        .ROW_WIDTH    (ROW_WIDTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_op              (op_head),
        .i_op_empty        (op_empty),
        .o_op_pop          (op_pop),
        .i_pop             (pop),
        .o_empty           (empty),
        .o_kind            (o_kind),
        .o_char_out        (o_char_out),
        .o_raw_row         (o_raw_row),
        .o_line_offset     (o_line_offset),
        .o_offset_overflow (o_offset_overflow),
        .o_last            (o_last)
    );

endmodule

/* design/lls_fifo.sv */
// ---------------------------------------------------------------------------
// Logical line splicer queue
// Small first-in first-out buffer of generic width.
// ---------------------------------------------------------------------------
module lls_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);

    logic [WIDTH-1:0]                r_mem [lls_pkg::QUEUE_DEPTH];
    logic [lls_pkg::QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [lls_pkg::QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [lls_pkg::QUEUE_CNT_W-1:0] r_count, n_count;
    logic                            wr_en, rd_en;

    assign o_full  = (r_count == lls_pkg::QUEUE_CNT_W'(lls_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == lls_pkg::QUEUE_PTR_W'(lls_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == lls_pkg::QUEUE_PTR_W'(lls_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

/* design/lls_front.sv */
// ---------------------------------------------------------------------------
// Logical line splicer front end
// Classify each accepted beat into an operation for the back end.
// ---------------------------------------------------------------------------
module lls_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    input  logic [7:0]   i_cfg_escape_byte,
    input  logic         i_accept,
    input  logic [7:0]   i_data_byte,
    input  logic         i_end_of_file,
    output logic         o_op_valid,
    output lls_pkg::t_op o_op
);

    logic [7:0] r_escape_byte;
    logic       r_escape_pending, n_escape_pending;
    logic       r_swallow_lf, n_swallow_lf;
    logic       r_stream_done, n_stream_done;
    logic       is_newline;
    logic       is_escape;

    assign is_newline = (i_data_byte == lls_pkg::LF_BYTE) || (i_data_byte == lls_pkg::CR_BYTE);
    assign is_escape  = (i_data_byte == r_escape_byte);

    always_comb begin
        n_escape_pending = r_escape_pending;
        n_swallow_lf     = r_swallow_lf;
        n_stream_done    = r_stream_done;
        o_op_valid       = 1'b0;
        o_op.code        = lls_pkg::OP_CHAR;
        o_op.byte0       = i_data_byte;
        o_op.byte1       = i_data_byte;
        if (i_accept && !r_stream_done) begin
            if (i_end_of_file) begin
                n_swallow_lf     = 1'b0;
                n_escape_pending = 1'b0;
                n_stream_done    = 1'b1;
                o_op_valid       = 1'b1;
                o_op.byte0       = r_escape_byte;
                o_op.code        = r_escape_pending ? lls_pkg::OP_CHAR_LINE_END :
                                                      lls_pkg::OP_LINE_END;
            end else if (r_swallow_lf && (i_data_byte == lls_pkg::LF_BYTE)) begin
                // drop the LF of a CR LF pair
                n_swallow_lf = 1'b0;
            end else begin
                n_swallow_lf = (i_data_byte == lls_pkg::CR_BYTE);
                if (r_escape_pending) begin
                    o_op_valid = 1'b1;
                    o_op.byte0 = r_escape_byte;
                    if (is_newline) begin
                        n_escape_pending = 1'b0;
                        o_op.code        = lls_pkg::OP_BOOKMARK;
                    end else if (is_escape) begin
                        // release the old escape, hold the new one
                        o_op.code = lls_pkg::OP_CHAR;
                    end else begin
                        n_escape_pending = 1'b0;
                        o_op.code        = lls_pkg::OP_CHAR_PAIR;
                    end
                end else if (is_newline) begin
                    o_op_valid = 1'b1;
                    o_op.code  = lls_pkg::OP_LINE_END;
                end else if (is_escape) begin
                    n_escape_pending = 1'b1;
                end else begin
                    o_op_valid = 1'b1;
                    o_op.code  = lls_pkg::OP_CHAR;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_byte    <= lls_pkg::ESCAPE_RESET;
            r_escape_pending <= 1'b0;
            r_swallow_lf     <= 1'b0;
            r_stream_done    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_escape_byte <= i_cfg_escape_byte;
            end
            r_escape_pending <= n_escape_pending;
            r_swallow_lf     <= n_swallow_lf;
            r_stream_done    <= n_stream_done;
        end
    end

endmodule

/* design/lls_back.sv */
// ---------------------------------------------------------------------------
// Logical line splicer back end
// Carry out operations, track row and offset, queue result beats.
// ---------------------------------------------------------------------------
`include "logical_line_splicer_assert.svh"

module lls_back #(
    parameter int OFFSET_WIDTH = 16,
    parameter int ROW_WIDTH    = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  lls_pkg::t_op            i_op,
    input  logic                    i_op_empty,
    output logic                    o_op_pop,
    input  logic                    i_pop,
    output logic                    o_empty,
    output logic [1:0]              o_kind,
    output logic [7:0]              o_char_out,
    output logic [ROW_WIDTH-1:0]    o_raw_row,
    output logic [OFFSET_WIDTH-1:0] o_line_offset,
    output logic                    o_offset_overflow,
    output logic                    o_last
);

    localparam int RES_W = 2 + 8 + ROW_WIDTH + OFFSET_WIDTH + 2;
    localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = '1;

    lls_pkg::t_back_state    r_state, n_state;
    logic [ROW_WIDTH-1:0]    r_row_count, n_row_count;
    logic [OFFSET_WIDTH-1:0] r_char_count, n_char_count;
    logic                    r_overflow_seen, n_overflow_seen;

    logic                    res_full;
    logic                    fire;
    logic                    two_beats;
    logic                    sel_char;
    logic                    sel_line_end;
    logic                    sel_bookmark;
    logic [7:0]              sel_byte;
    lls_pkg::t_kind          res_kind;
    logic [7:0]              res_char;
    logic [ROW_WIDTH-1:0]    res_row;
    logic [OFFSET_WIDTH-1:0] res_offset;
    logic                    res_ovf;
    logic                    res_last;
    logic [RES_W-1:0]        res_wdata;
    logic [RES_W-1:0]        res_rdata;

    assign fire      = !i_op_empty && !res_full;
    assign two_beats = (i_op.code == lls_pkg::OP_CHAR_PAIR) ||
                       (i_op.code == lls_pkg::OP_CHAR_LINE_END);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lls_pkg::BK_FIRST: begin
                if (fire && two_beats) begin
                    n_state = lls_pkg::BK_SECOND;
                end
            end
            lls_pkg::BK_SECOND: begin
                if (fire) begin
                    n_state = lls_pkg::BK_FIRST;
                end
            end
            default: n_state = lls_pkg::BK_FIRST;
        endcase
    end

    // beat selection per state
    always_comb begin
        sel_char     = 1'b0;
        sel_line_end = 1'b0;
        sel_bookmark = 1'b0;
        sel_byte     = i_op.byte0;
        res_last     = 1'b1;
        case (r_state)
            lls_pkg::BK_FIRST: begin
                case (i_op.code)
                    lls_pkg::OP_CHAR: sel_char = 1'b1;
                    lls_pkg::OP_CHAR_PAIR, lls_pkg::OP_CHAR_LINE_END: begin
                        sel_char = 1'b1;
                        res_last = 1'b0;
                    end
                    lls_pkg::OP_LINE_END: sel_line_end = 1'b1;
                    lls_pkg::OP_BOOKMARK: sel_bookmark = 1'b1;
                    default: sel_char = 1'b1;
                endcase
            end
            lls_pkg::BK_SECOND: begin
                if (i_op.code == lls_pkg::OP_CHAR_LINE_END) begin
                    sel_line_end = 1'b1;
                end else begin
                    sel_char = 1'b1;
                    sel_byte = i_op.byte1;
                end
            end
            default: sel_char = 1'b1;
        endcase
        o_op_pop = fire && res_last;
    end

    // result fields and counter updates
    always_comb begin
        n_row_count     = r_row_count;
        n_char_count    = r_char_count;
        n_overflow_seen = r_overflow_seen;
        res_kind        = lls_pkg::KIND_CHAR;
        res_char        = 8'h00;
        res_row         = r_row_count;
        res_offset      = r_char_count;
        res_ovf         = r_overflow_seen;
        if (sel_char) begin
            res_char = sel_byte;
            if (fire) begin
                if (r_char_count == OFFSET_MAX) begin
                    n_overflow_seen = 1'b1;
                end else begin
                    n_char_count = r_char_count + 1'b1;
                end
            end
        end else if (sel_line_end) begin
            res_kind = lls_pkg::KIND_LINE_END;
            if (fire) begin
                n_row_count     = r_row_count + 1'b1;
                n_char_count    = '0;
                n_overflow_seen = 1'b0;
            end
        end else if (sel_bookmark) begin
            res_kind = lls_pkg::KIND_BOOKMARK;
            res_row  = r_row_count + 1'b1;
            if (fire) begin
                n_row_count = r_row_count + 1'b1;
            end
        end
    end

    assign res_wdata = {res_kind, res_char, res_row, res_offset, res_ovf, res_last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= lls_pkg::BK_FIRST;
            r_row_count     <= ROW_WIDTH'(1);
            r_char_count    <= '0;
            r_overflow_seen <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_row_count     <= n_row_count;
            r_char_count    <= n_char_count;
            r_overflow_seen <= n_overflow_seen;
        end
    end

    lls_fifo #(
        .WIDTH (RES_W)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fire),
        .i_wdata (res_wdata),
        .i_rd    (i_pop),
        .o_rdata (res_rdata),
        .o_full  (res_full),
        .o_empty (o_empty)
    );

    assign o_kind            = res_rdata[RES_W-1 -: 2];
    assign o_char_out        = res_rdata[RES_W-3 -: 8];
    assign o_raw_row         = res_rdata[OFFSET_WIDTH+2 +: ROW_WIDTH];
    assign o_line_offset     = res_rdata[2 +: OFFSET_WIDTH];
    assign o_offset_overflow = res_rdata[1];
    assign o_last            = res_rdata[0];

    `LLS_ASSERT_SAME(a_second_needs_pair, r_state == lls_pkg::BK_SECOND, !i_op_empty && two_beats)
    `LLS_ASSERT_SAME(a_pop_on_last, o_op_pop, fire && res_last)
    `LLS_ASSERT_SAME(a_overflow_at_max, r_overflow_seen, r_char_count == OFFSET_MAX)
    `LLS_ASSERT_NEXT(a_line_end_clears, fire && sel_line_end, r_char_count == '0 && !r_overflow_seen)

endmodule

/* tb/logical_line_splicer_test.sv */
// ---------------------------------------------------------------------------
// Logical line splicer testbench
// Feeds raw bytes through the input queue and compares every result beat with
// a cycle-free model of the splicer kept in step with each accepted beat.
// Covers the newline forms, escape splicing under several escape bytes,
// random byte streams with one flat-out phase, and the closing end-of-file
// with everything after it ignored.
// ---------------------------------------------------------------------------
module logical_line_splicer_test;

    // one result beat as the splicer should produce it
    typedef struct packed {
        lls_pkg::t_kind kind;
        logic [7:0]     ch;
        logic [31:0]    row;
        logic [15:0]    off;
        logic           ovf;
        logic           last;
    } t_splice_beat;

    // clock and block ports; every input starts at a known value
    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        i_cfg_valid       = 1'b0;
    logic [7:0]  i_cfg_escape_byte = 8'h00;
    logic        push              = 1'b0;
    logic [7:0]  i_data_byte       = 8'h00;
    logic        i_end_of_file     = 1'b0;
    logic        pop               = 1'b0;
    logic        o_cfg_ready;
    logic        full;
    logic        empty;
    logic [1:0]  o_kind;
    logic [7:0]  o_char_out;
    logic [31:0] o_raw_row;
    logic [15:0] o_line_offset;
    logic        o_offset_overflow;
    logic        o_last;

    // model state of the splicer
    logic [7:0]  esc_byte      = lls_pkg::ESCAPE_RESET;
    logic        esc_held      = 1'b0;
    logic        drop_lf       = 1'b0;
    logic [31:0] row_now       = 32'd1;
    logic [15:0] col_now       = 16'd0;
    logic        col_sat       = 1'b0;
    logic        stream_closed = 1'b0;

    // result beats still owed by the block, oldest first
    t_splice_beat line_beats[$];

    // run bookkeeping
    logic idle_on      = 1'b1;
    int   mismatches   = 0;
    int   items_sent   = 0;
    int   beats_seen   = 0;
    int   bookmarks    = 0;
    int   line_ends    = 0;
    int   escape_sets  = 0;

    logical_line_splicer dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_escape_byte (i_cfg_escape_byte),
        .push              (push),
        .full              (full),
        .i_data_byte       (i_data_byte),
        .i_end_of_file     (i_end_of_file),
        .empty             (empty),
        .pop               (pop),
        .o_kind            (o_kind),
        .o_char_out        (o_char_out),
        .o_raw_row         (o_raw_row),
        .o_line_offset     (o_line_offset),
        .o_offset_overflow (o_offset_overflow),
        .o_last            (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Model of the splicer
    // -----------------------------------------------------------------------

    // Emit a character at the current offset; hold the offset at its maximum
    // and raise the overflow flag once the line runs past it.
    function automatic t_splice_beat char_beat(input logic [7:0] ch);
        t_splice_beat bt;
        bt.kind = lls_pkg::KIND_CHAR;
        bt.ch   = ch;
        bt.row  = row_now;
        bt.off  = col_now;
        bt.ovf  = col_sat;
        bt.last = 1'b0;
        if (col_now == 16'hFFFF)
            col_sat = 1'b1;
        else
            col_now = col_now + 16'd1;
        return bt;
    endfunction

    // Close the logical line: report its length, advance to a fresh row.
    function automatic t_splice_beat line_end_beat();
        t_splice_beat bt;
        bt.kind = lls_pkg::KIND_LINE_END;
        bt.ch   = 8'h00;
        bt.row  = row_now;
        bt.off  = col_now;
        bt.ovf  = col_sat;
        bt.last = 1'b0;
        row_now = row_now + 32'd1;
        col_now = 16'd0;
        col_sat = 1'b0;
        return bt;
    endfunction

    // Splice: advance the raw row but keep the logical line going.
    function automatic t_splice_beat bookmark_beat();
        t_splice_beat bt;
        row_now = row_now + 32'd1;
        bt.kind = lls_pkg::KIND_BOOKMARK;
        bt.ch   = 8'h00;
        bt.row  = row_now;
        bt.off  = col_now;
        bt.ovf  = col_sat;
        bt.last = 1'b0;
        return bt;
    endfunction

    // Advance the model by one accepted input beat and queue what it causes.
    task automatic splice_step(input logic [7:0] b, input logic eof);
        t_splice_beat outb [2];
        int           n;
        logic         newline;
        n = 0;
        if (stream_closed)
            return;
        if (eof) begin
            drop_lf = 1'b0;
            // flush a held escape as a plain character before closing
            if (esc_held) begin
                esc_held = 1'b0;
                outb[n]  = char_beat(esc_byte);
                n++;
            end
            outb[n] = line_end_beat();
            n++;
            stream_closed = 1'b1;
        end else begin
            // LF right after CR belongs to the same newline
            if (drop_lf) begin
                drop_lf = 1'b0;
                if (b == lls_pkg::LF_BYTE)
                    return;
            end
            newline = (b == lls_pkg::LF_BYTE) || (b == lls_pkg::CR_BYTE);
            if (b == lls_pkg::CR_BYTE)
                drop_lf = 1'b1;
            if (esc_held) begin
                if (newline) begin
                    esc_held = 1'b0;
                    outb[n]  = bookmark_beat();
                    n++;
                end else begin
                    outb[n] = char_beat(esc_byte);
                    n++;
                    if (b == esc_byte) begin
                        esc_held = 1'b1;
                    end else begin
                        esc_held = 1'b0;
                        outb[n]  = char_beat(b);
                        n++;
                    end
                end
            end else if (newline) begin
                outb[n] = line_end_beat();
                n++;
            end else if (b == esc_byte) begin
                esc_held = 1'b1;
            end else begin
                outb[n] = char_beat(b);
                n++;
            end
        end
        if (n > 0)
            outb[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            line_beats.push_back(outb[i]);
    endtask

    // -----------------------------------------------------------------------
    // Result side: random or steady pop, check every beat that leaves the block
    // -----------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at result beat %0d: %s got %0h want %0h",
                 beats_seen, what, got, want);
        mismatches++;
    endtask

    task automatic check_beat();
        t_splice_beat want;
        if (line_beats.size() == 0) begin
            report_mismatch("unexpected beat, kind", 32'(o_kind), 32'd0);
        end else begin
            want = line_beats.pop_front();
            if (o_kind !== want.kind)
                report_mismatch("kind", 32'(o_kind), 32'(want.kind));
            if (o_char_out !== want.ch)
                report_mismatch("char_out", 32'(o_char_out), 32'(want.ch));
            if (o_raw_row !== want.row)
                report_mismatch("raw_row", o_raw_row, want.row);
            if (o_line_offset !== want.off)
                report_mismatch("line_offset", 32'(o_line_offset), 32'(want.off));
            if (o_offset_overflow !== want.ovf)
                report_mismatch("offset_overflow", 32'(o_offset_overflow),
                                32'(want.ovf));
            if (o_last !== want.last)
                report_mismatch("last", 32'(o_last), 32'(want.last));
            if (want.kind == lls_pkg::KIND_BOOKMARK)
                bookmarks++;
            if (want.kind == lls_pkg::KIND_LINE_END)
                line_ends++;
        end
        beats_seen++;
    endtask

    // Drive pop at the falling edge, take the beat at the rising edge.
    initial begin
        forever begin
            @(negedge i_clk);
            pop <= idle_on ? ($urandom_range(0, 99) >= 30) : 1'b1;
            @(posedge i_clk);
            if (i_rst_n && pop && !empty)
                check_beat();
        end
    end

    // -----------------------------------------------------------------------
    // Input side helpers; each is entered and left at a falling edge
    // -----------------------------------------------------------------------

    // Offer one beat, idling first at random; hold it until full drops.
    // Push is left high so back-to-back beats need no extra assignment.
    task automatic send_item(input logic [7:0] b, input logic eof);
        while (idle_on && $urandom_range(0, 99) < 30) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push          <= 1'b1;
        i_data_byte   <= b;
        i_end_of_file <= eof;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        splice_step(b, eof);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Drop push, wait for every owed beat, then let the back end go quiet.
    task automatic settle_inputs();
        push <= 1'b0;
        while (line_beats.size() != 0)
            @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    // Write the escape byte while the block is idle, with no escape held.
    task automatic set_escape(input logic [7:0] v);
        while (esc_held)
            send_item(lls_pkg::LF_BYTE, 1'b0);
        settle_inputs();
        i_cfg_valid       <= 1'b1;
        i_cfg_escape_byte <= v;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        esc_byte = v;
        escape_sets++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // A byte that is neither a newline nor the current escape byte.
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == lls_pkg::LF_BYTE || b == lls_pkg::CR_BYTE || b == esc_byte)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Newline forms and escape handling under the reset escape byte.
    task automatic test_directed_lines();
        logic [7:0] seq [$];
        seq = '{8'h61, 8'h00, 8'hFF,                                   // extremes
                lls_pkg::ESCAPE_RESET, lls_pkg::LF_BYTE, 8'h62,        // splice LF
                lls_pkg::ESCAPE_RESET, lls_pkg::CR_BYTE, lls_pkg::LF_BYTE,
                8'h63, lls_pkg::ESCAPE_RESET, 8'h78,                   // esc, plain
                lls_pkg::ESCAPE_RESET, lls_pkg::ESCAPE_RESET, lls_pkg::LF_BYTE,
                lls_pkg::CR_BYTE, lls_pkg::LF_BYTE,                    // CR LF
                lls_pkg::CR_BYTE, lls_pkg::CR_BYTE, lls_pkg::LF_BYTE,  // CR CR LF
                lls_pkg::LF_BYTE,                                      // empty line
                lls_pkg::CR_BYTE, 8'h71};                              // CR, plain
        foreach (seq[i])
            send_item(seq[i], 1'b0);
    endtask

    // Escape bytes at the extremes and equal to the newline bytes.
    task automatic test_escape_settings();
        logic [7:0] values [4];
        values = '{8'h00, 8'hFF, lls_pkg::LF_BYTE, lls_pkg::CR_BYTE};
        foreach (values[i]) begin
            set_escape(values[i]);
            send_item(8'h7A, 1'b0);
            send_item(values[i], 1'b0);
            send_item(lls_pkg::LF_BYTE, 1'b0);
            send_item(8'h41, 1'b0);
            send_item(values[i], 1'b0);
            send_item(lls_pkg::CR_BYTE, 1'b0);
            send_item(lls_pkg::LF_BYTE, 1'b0);
            send_item(values[i], 1'b0);
            send_item(8'h6B, 1'b0);
            send_item(values[i], 1'b0);
            send_item(values[i], 1'b0);
            send_item(lls_pkg::LF_BYTE, 1'b0);
        end
    endtask

    // Send one random newline form: LF, CR, or CR LF.
    task automatic send_newline();
        case ($urandom_range(0, 2))
            0: begin
                send_item(lls_pkg::LF_BYTE, 1'b0);
            end
            1: begin
                send_item(lls_pkg::CR_BYTE, 1'b0);
            end
            default: begin
                send_item(lls_pkg::CR_BYTE, 1'b0);
                send_item(lls_pkg::LF_BYTE, 1'b0);
            end
        endcase
    endtask

    // Mostly well-formed text with splices and newlines, some raw noise.
    task automatic test_random_stream();
        logic [7:0] settings [5];
        int         r;
        int         start;
        settings = '{lls_pkg::ESCAPE_RESET, 8'($urandom_range(0, 255)), 8'h5C,
                     8'($urandom_range(0, 255)), lls_pkg::ESCAPE_RESET};
        foreach (settings[p]) begin
            set_escape(settings[p]);
            // one phase runs flat out on both sides
            idle_on = (p != 2);
            start   = items_sent;
            while (items_sent - start < 120) begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    send_item(plain_byte(), 1'b0);
                end else if (r < 65) begin
                    send_item(esc_byte, 1'b0);
                    send_newline();
                end else if (r < 78) begin
                    send_newline();
                end else if (r < 84) begin
                    send_item(esc_byte, 1'b0);
                    send_item(plain_byte(), 1'b0);
                end else if (r < 88) begin
                    send_item(esc_byte, 1'b0);
                    send_item(esc_byte, 1'b0);
                end else begin
                    send_item(8'($urandom_range(0, 255)), 1'b0);
                end
            end
        end
        idle_on = 1'b1;
    endtask

    // Close the stream with an escape held, then check nothing follows.
    task automatic test_end_of_file();
        set_escape(lls_pkg::ESCAPE_RESET);
        send_item(8'h65, 1'b0);
        send_item(lls_pkg::ESCAPE_RESET, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
        repeat (6)
            send_item(8'($urandom_range(0, 255)), 1'b0);
        send_item(lls_pkg::ESCAPE_RESET, 1'b0);
        send_item(lls_pkg::LF_BYTE, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
        settle_inputs();
    endtask

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_lines();
        test_escape_settings();
        test_random_stream();
        test_end_of_file();

        // give any stray beat time to show up after the last owed one
        repeat (20) @(negedge i_clk);
        if (line_beats.size() != 0)
            report_mismatch("beats never delivered", 32'(line_beats.size()), 32'd0);

        $display("ran %0d input beats over %0d escape settings, one phase flat out",
                 items_sent, escape_sets);
        $display("checked %0d result beats: %0d bookmarks, %0d line ends, %0d mismatches",
                 beats_seen, bookmarks, line_ends, mismatches);
        if (mismatches == 0)
            $display("logical_line_splicer_test: clean");
        else
            $display("logical_line_splicer_test: errors");
        $finish;
    end

    // Hard stop if the block hangs a handshake.
    initial begin
        #200000;
        $display("timeout waiting on the block");
        $display("logical_line_splicer_test: errors");
        $finish;
    end

endmodule
